// ----- hw/rtl/slt_pkg.sv -----
`timescale 1ns / 1ps
package slt_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_ENTRIES = 8192;
    localparam int VALUE_BITS  = 32;
    localparam int ROW_AW      = $clog2(MAX_ROWS);
    localparam int ENT_AW      = $clog2(MAX_ENTRIES);
    localparam int START_W     = ENT_AW + 1;
    localparam int START_AW    = ROW_AW + 1;
    localparam int SIZE_W      = ROW_AW + 1;
    localparam int ACC_W       = 2 * VALUE_BITS;
    localparam int NUM_MAG_W   = ACC_W - 1;
    localparam int DIV_STEPS   = NUM_MAG_W + 16;
    localparam int QUOT_W      = VALUE_BITS + 2;
    localparam int COUNT_MAX   = MAX_ROWS - 1;

    localparam logic [2:0] CMD_ROW_ENTRY = 3'd0;
    localparam logic [2:0] CMD_COL_ENTRY = 3'd1;
    localparam logic [2:0] CMD_RHS       = 3'd2;
    localparam logic [2:0] CMD_SOLVE     = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_DIAG = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;
    localparam logic [1:0] ST_UNSOLVED  = 2'd3;

    typedef struct packed {
        logic [2:0]                   command;
        logic [ROW_AW-1:0]            row_index;
        logic [ROW_AW-1:0]            col_index;
        logic signed [VALUE_BITS-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic                         kind;
        logic signed [VALUE_BITS-1:0] data;
        logic [1:0]                   status;
        logic [SIZE_W-1:0]            solved_count;
    } t_res;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SWEEP_RD, S_SWEEP_WR, S_POP, S_POPW, S_ROW,
        S_ENT, S_ENTW, S_XW, S_ACC, S_DIAGW, S_NUM, S_DIV, S_UPD,
        S_DEP, S_DEPW, S_PENDW, S_DONE, S_READW
    } t_state;

    function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [ACC_W:0] a);
        logic signed [ACC_W:0] lim;
        lim = (ACC_W+1)'(1) <<< (ACC_W - 2);
        if (a > lim) begin
            return lim[ACC_W-1:0];
        end else if (a < -lim) begin
            lim = -lim;
            return lim[ACC_W-1:0];
        end
        return a[ACC_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/slt_div.sv -----
`timescale 1ns / 1ps
module slt_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [slt_pkg::NUM_MAG_W-1:0]        i_num,
    input  logic [slt_pkg::VALUE_BITS-1:0]       i_den,
    output slt_pkg::t_div_res                    o_res
);
    localparam int DW = slt_pkg::DIV_STEPS;
    localparam int CW = $clog2(DW + 1);

    logic                               r_busy;
    logic [CW-1:0]                      r_cnt;
    logic [DW-1:0]                      r_dvd;
    logic [slt_pkg::VALUE_BITS-1:0]     r_den;
    logic [slt_pkg::VALUE_BITS-1:0]     r_rem;
    logic [slt_pkg::QUOT_W-1:0]         r_quot;
    logic                               r_ovf;
    logic                               r_done;
    logic [slt_pkg::VALUE_BITS:0]       rem_sh;
    logic [slt_pkg::VALUE_BITS:0]       rem_sub;
    logic                               take;

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_dvd[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign take    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_dvd  <= {i_num, 16'b0};
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_rem  <= take ? rem_sub[slt_pkg::VALUE_BITS-1:0]
                               : rem_sh[slt_pkg::VALUE_BITS-1:0];
                r_dvd  <= {r_dvd[DW-2:0], 1'b0};
                r_quot <= {r_quot[slt_pkg::QUOT_W-2:0], take};
                r_ovf  <= r_ovf | r_quot[slt_pkg::QUOT_W-1];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_quot;
endmodule

// ----- hw/rtl/sparse_lower_solve_dependency_driven.sv -----
`timescale 1ns / 1ps
// sparse lower-triangular forward solve in Q16.16, rows taken in dependency order
// a command transaction is taken when start is high and busy is low; busy stays
// high until the command is done. row entries, column pattern entries and rhs
// elements are written as they are taken and never raise busy. read solution answers
// through the S_READW state and the output register with one strobe on o_res_valid.
// solve gives one report strobe after a sweep over the start tables, then per row
// a pass over its off-diagonal entries, the serial divider and an update of each
// dependent row; the single multiplier and the bit-serial divider serialise that
// work. results are never held back: the strobe lasts one cycle.
// the configuration register (matrix size) is written with i_cfg_we; the user must
// write it only while the block is idle, the block itself does not enforce it.
// after reset the block runs a clearing pass over the start tables and the solution
// store with busy high.
module sparse_lower_solve_dependency_driven (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  slt_pkg::t_cmd                     i_cmd,
    output logic                              o_res_valid,
    output slt_pkg::t_res                     o_res,
    input  logic                              i_cfg_we,
    input  logic [slt_pkg::SIZE_W-1:0]        i_cfg_data
);
    localparam int VB  = slt_pkg::VALUE_BITS;
    localparam int RA  = slt_pkg::ROW_AW;
    localparam int EA  = slt_pkg::ENT_AW;
    localparam int SW  = slt_pkg::START_W;
    localparam int SA  = slt_pkg::START_AW;
    localparam int ZW  = slt_pkg::SIZE_W;
    localparam int AW  = slt_pkg::ACC_W;

    // memories
    logic [RA+VB-1:0] mem_ent [slt_pkg::MAX_ENTRIES];
    logic [RA-1:0]    mem_dep [slt_pkg::MAX_ENTRIES];
    logic [VB-1:0]    mem_rhs [slt_pkg::MAX_ROWS];
    logic [VB-1:0]    mem_sol [slt_pkg::MAX_ROWS];
    logic [RA-1:0]    mem_pend [slt_pkg::MAX_ROWS];
    logic [RA-1:0]    mem_fifo [slt_pkg::MAX_ROWS];
    logic [SW:0]      mem_rs [slt_pkg::MAX_ROWS+1];
    logic [SW:0]      mem_cs [slt_pkg::MAX_ROWS+1];

    logic            ent_we;  logic [EA-1:0] ent_wa, ent_ra; logic [RA+VB-1:0] ent_wd, r_ent_q;
    logic            dep_we;  logic [EA-1:0] dep_wa, dep_ra; logic [RA-1:0] dep_wd, r_dep_q;
    logic            rhs_we;  logic [RA-1:0] rhs_wa, rhs_ra; logic [VB-1:0] rhs_wd, r_rhs_q;
    logic            sol_we;  logic [RA-1:0] sol_wa, sol_ra; logic [VB-1:0] sol_wd, r_sol_q;
    logic            pend_we; logic [RA-1:0] pend_wa, pend_ra, pend_wd, r_pend_q;
    logic            fifo_we; logic [RA-1:0] fifo_wa, fifo_ra, fifo_wd, r_fifo_q;
    logic            rs_we;   logic [SA-1:0] rs_wa, rs_ra0, rs_ra1; logic [SW:0] rs_wd;
    logic [SW:0]     r_rs_q0, r_rs_q1;
    logic            cs_we;   logic [SA-1:0] cs_wa, cs_ra0, cs_ra1; logic [SW:0] cs_wd;
    logic [SW:0]     r_cs_q0, r_cs_q1;

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_ent[ent_wa] <= ent_wd;
        end
        r_ent_q <= mem_ent[ent_ra];
    end
    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            mem_dep[dep_wa] <= dep_wd;
        end
        r_dep_q <= mem_dep[dep_ra];
    end
    always_ff @(posedge i_clk) begin
        if (rhs_we) begin
            mem_rhs[rhs_wa] <= rhs_wd;
        end
        r_rhs_q <= mem_rhs[rhs_ra];
    end
    always_ff @(posedge i_clk) begin
        if (sol_we) begin
            mem_sol[sol_wa] <= sol_wd;
        end
        r_sol_q <= mem_sol[sol_ra];
    end
    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            mem_pend[pend_wa] <= pend_wd;
        end
        r_pend_q <= mem_pend[pend_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            mem_fifo[fifo_wa] <= fifo_wd;
        end
        r_fifo_q <= mem_fifo[fifo_ra];
    end
    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            mem_rs[rs_wa] <= rs_wd;
        end
        r_rs_q0 <= mem_rs[rs_ra0];
        r_rs_q1 <= mem_rs[rs_ra1];
    end
    always_ff @(posedge i_clk) begin
        if (cs_we) begin
            mem_cs[cs_wa] <= cs_wd;
        end
        r_cs_q0 <= mem_cs[cs_ra0];
        r_cs_q1 <= mem_cs[cs_ra1];
    end

    // control and datapath registers
    slt_pkg::t_state r_state, n_state;
    logic [ZW-1:0]   r_msize, n_msize;
    logic            r_row_open, n_row_open, r_col_open, n_col_open;
    logic            r_g_row, n_g_row, r_g_col, n_g_col;
    logic [SW-1:0]   r_row_fill, n_row_fill, r_col_fill, n_col_fill;
    logic [ZW-1:0]   r_last, n_last, r_solved, n_solved;
    logic [SA-1:0]   r_idx, n_idx;
    logic [SW-1:0]   r_run_r, n_run_r, r_run_c, n_run_c;
    logic [ZW-1:0]   r_head, n_head, r_tail, n_tail;
    logic [RA-1:0]   r_row, n_row, r_dep, n_dep;
    logic [SW-1:0]   r_j, n_j, r_e, n_e, r_k, n_k, r_kend, n_kend;
    logic signed [VB-1:0] r_val, n_val, r_diag, n_diag, r_rhs, n_rhs;
    logic signed [AW-1:0] r_prod, n_prod, r_acc, n_acc;
    logic            r_zd, n_zd, r_sat, n_sat, r_neg, n_neg;
    logic            r_out_v, n_out_v;
    slt_pkg::t_res   r_out, n_out;

    logic            div_start;
    logic [slt_pkg::NUM_MAG_W-1:0] div_num;
    logic [VB-1:0]   div_den;
    slt_pkg::t_div_res div_res;

    slt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= slt_pkg::S_CLEAR;
            r_msize    <= ZW'(1);
            r_row_open <= 1'b0;
            r_col_open <= 1'b0;
            r_g_row    <= 1'b0;
            r_g_col    <= 1'b0;
            r_row_fill <= '0;
            r_col_fill <= '0;
            r_last     <= '0;
            r_idx      <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_msize    <= n_msize;
            r_row_open <= n_row_open;
            r_col_open <= n_col_open;
            r_g_row    <= n_g_row;
            r_g_col    <= n_g_col;
            r_row_fill <= n_row_fill;
            r_col_fill <= n_col_fill;
            r_last     <= n_last;
            r_idx      <= n_idx;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_solved <= n_solved;
        r_run_r  <= n_run_r;
        r_run_c  <= n_run_c;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_row    <= n_row;
        r_dep    <= n_dep;
        r_j      <= n_j;
        r_e      <= n_e;
        r_k      <= n_k;
        r_kend   <= n_kend;
        r_val    <= n_val;
        r_diag   <= n_diag;
        r_rhs    <= n_rhs;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_zd     <= n_zd;
        r_sat    <= n_sat;
        r_neg    <= n_neg;
        r_out    <= n_out;
    end

    logic [ZW-1:0]   n_rows;
    logic [SW-1:0]   eff_fill, fill_inc;
    logic            eff_g;
    logic [SW-1:0]   rs_v0, rs_v1, cs_v0, cs_v1, m_r, m_c, len;
    logic [SW-1:0]   cnt;
    logic signed [AW:0] sum_wide;
    logic signed [AW-1:0] num;
    logic [slt_pkg::QUOT_W-1:0] lim;
    logic            big;
    logic [ZW-1:0]   row_i;

    assign n_rows = (r_msize > ZW'(slt_pkg::MAX_ROWS)) ? ZW'(slt_pkg::MAX_ROWS) : r_msize;
    // a start-table entry from an older load epoch reads as zero
    assign rs_v0 = (r_rs_q0[SW] == r_g_row) ? r_rs_q0[SW-1:0] : '0;
    assign rs_v1 = (r_rs_q1[SW] == r_g_row) ? r_rs_q1[SW-1:0] : '0;
    assign cs_v0 = (r_cs_q0[SW] == r_g_col) ? r_cs_q0[SW-1:0] : '0;
    assign cs_v1 = (r_cs_q1[SW] == r_g_col) ? r_cs_q1[SW-1:0] : '0;
    assign busy  = (r_state != slt_pkg::S_IDLE);
    assign o_res_valid = r_out_v;
    assign o_res = r_out;

    always_comb begin
        n_state = r_state;   n_msize = r_msize;
        n_row_open = r_row_open; n_col_open = r_col_open;
        n_g_row = r_g_row;   n_g_col = r_g_col;
        n_row_fill = r_row_fill; n_col_fill = r_col_fill;
        n_last = r_last;     n_solved = r_solved; n_idx = r_idx;
        n_run_r = r_run_r;   n_run_c = r_run_c;
        n_head = r_head;     n_tail = r_tail;
        n_row = r_row;       n_dep = r_dep;
        n_j = r_j;           n_e = r_e; n_k = r_k; n_kend = r_kend;
        n_val = r_val;       n_diag = r_diag; n_rhs = r_rhs;
        n_prod = r_prod;     n_acc = r_acc;
        n_zd = r_zd;         n_sat = r_sat; n_neg = r_neg;
        n_out_v = 1'b0;      n_out = r_out;
        ent_we = 1'b0; ent_wa = '0; ent_wd = '0; ent_ra = r_j[EA-1:0];
        dep_we = 1'b0; dep_wa = '0; dep_wd = '0; dep_ra = r_k[EA-1:0];
        rhs_we = 1'b0; rhs_wa = '0; rhs_wd = '0; rhs_ra = r_row;
        sol_we = 1'b0; sol_wa = '0; sol_wd = '0; sol_ra = r_row;
        pend_we = 1'b0; pend_wa = '0; pend_wd = '0; pend_ra = r_dep;
        fifo_we = 1'b0; fifo_wa = r_tail[RA-1:0]; fifo_wd = '0;
        fifo_ra = r_head[RA-1:0];
        rs_we = 1'b0; rs_wa = '0; rs_wd = '0; rs_ra0 = r_idx; rs_ra1 = r_idx;
        cs_we = 1'b0; cs_wa = '0; cs_wd = '0; cs_ra0 = r_idx; cs_ra1 = r_idx;
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;
        eff_fill = '0; fill_inc = '0; eff_g = 1'b0;
        m_r = '0; m_c = '0; len = '0; cnt = '0;
        sum_wide = '0; num = '0; lim = '0; big = 1'b0; row_i = '0;

        if (i_cfg_we) begin
            n_msize = i_cfg_data;
        end

        case (r_state)
            slt_pkg::S_CLEAR: begin
                rs_we = 1'b1; rs_wa = r_idx; rs_wd = '0;
                cs_we = 1'b1; cs_wa = r_idx; cs_wd = '0;
                sol_we = (r_idx < SA'(slt_pkg::MAX_ROWS));
                sol_wa = r_idx[RA-1:0]; sol_wd = '0;
                n_idx = r_idx + 1'b1;
                if (r_idx == SA'(slt_pkg::MAX_ROWS)) begin
                    n_idx = '0;
                    n_state = slt_pkg::S_IDLE;
                end
            end
            slt_pkg::S_IDLE: begin
                if (start) begin
                    case (i_cmd.command)
                        slt_pkg::CMD_ROW_ENTRY: begin
                            // first row entry after a solve opens a new matrix
                            eff_fill = r_row_open ? r_row_fill : '0;
                            eff_g    = r_row_open ? r_g_row : ~r_g_row;
                            fill_inc = eff_fill + 1'b1;
                            n_g_row = eff_g;
                            n_row_open = 1'b1;
                            n_row_fill = eff_fill;
                            if (eff_fill < SW'(slt_pkg::MAX_ENTRIES)) begin
                                ent_we = 1'b1; ent_wa = eff_fill[EA-1:0];
                                ent_wd = {i_cmd.col_index, i_cmd.value};
                                rs_we = 1'b1; rs_wa = {1'b0, i_cmd.row_index} + 1'b1;
                                rs_wd = {eff_g, fill_inc};
                                n_row_fill = fill_inc;
                            end
                        end
                        slt_pkg::CMD_COL_ENTRY: begin
                            eff_fill = r_col_open ? r_col_fill : '0;
                            eff_g    = r_col_open ? r_g_col : ~r_g_col;
                            fill_inc = eff_fill + 1'b1;
                            n_g_col = eff_g;
                            n_col_open = 1'b1;
                            n_col_fill = eff_fill;
                            if (eff_fill < SW'(slt_pkg::MAX_ENTRIES)) begin
                                dep_we = 1'b1; dep_wa = eff_fill[EA-1:0];
                                dep_wd = i_cmd.row_index;
                                cs_we = 1'b1; cs_wa = {1'b0, i_cmd.col_index} + 1'b1;
                                cs_wd = {eff_g, fill_inc};
                                n_col_fill = fill_inc;
                            end
                        end
                        slt_pkg::CMD_RHS: begin
                            rhs_we = 1'b1; rhs_wa = i_cmd.row_index; rhs_wd = i_cmd.value;
                        end
                        slt_pkg::CMD_SOLVE: begin
                            n_idx = '0; n_run_r = '0; n_run_c = '0;
                            n_head = '0; n_tail = '0; n_solved = '0;
                            n_zd = 1'b0; n_sat = 1'b0;
                            n_state = slt_pkg::S_SWEEP_RD;
                        end
                        slt_pkg::CMD_READ: begin
                            sol_ra = i_cmd.row_index;
                            n_state = slt_pkg::S_READW;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            slt_pkg::S_SWEEP_RD: begin
                n_state = slt_pkg::S_SWEEP_WR;
            end
            slt_pkg::S_SWEEP_WR: begin
                // running maximum over both start tables, counts for row idx-1
                m_r = (rs_v0 > r_run_r) ? rs_v0 : r_run_r;
                m_c = (cs_v0 > r_run_c) ? cs_v0 : r_run_c;
                rs_we = 1'b1; rs_wa = r_idx; rs_wd = {r_g_row, m_r};
                cs_we = 1'b1; cs_wa = r_idx; cs_wd = {r_g_col, m_c};
                len = m_r - r_run_r;
                cnt = (len == '0) ? '0 : len - 1'b1;
                if (cnt > SW'(slt_pkg::COUNT_MAX)) begin
                    cnt = SW'(slt_pkg::COUNT_MAX);
                end
                row_i = ZW'(r_idx) - 1'b1;
                if (r_idx != '0 && ZW'(r_idx) <= n_rows) begin
                    pend_we = 1'b1; pend_wa = row_i[RA-1:0]; pend_wd = cnt[RA-1:0];
                    sol_we = 1'b1; sol_wa = row_i[RA-1:0]; sol_wd = '0;
                    if (cnt == '0) begin
                        fifo_we = 1'b1; fifo_wd = row_i[RA-1:0];
                        n_tail = r_tail + 1'b1;
                    end
                end
                n_run_r = m_r;
                n_run_c = m_c;
                n_idx = r_idx + 1'b1;
                n_state = slt_pkg::S_SWEEP_RD;
                if (r_idx == SA'(slt_pkg::MAX_ROWS)) begin
                    n_state = slt_pkg::S_POP;
                end
            end
            slt_pkg::S_POP: begin
                if (r_head < r_tail) begin
                    n_head = r_head + 1'b1;
                    n_state = slt_pkg::S_POPW;
                end else begin
                    n_state = slt_pkg::S_DONE;
                end
            end
            slt_pkg::S_POPW: begin
                n_row = r_fifo_q;
                rs_ra0 = {1'b0, r_fifo_q}; rs_ra1 = {1'b0, r_fifo_q} + 1'b1;
                cs_ra0 = {1'b0, r_fifo_q}; cs_ra1 = {1'b0, r_fifo_q} + 1'b1;
                rhs_ra = r_fifo_q;
                n_state = slt_pkg::S_ROW;
            end
            slt_pkg::S_ROW: begin
                n_j = rs_v0; n_e = rs_v1;
                n_k = cs_v0 + 1'b1; n_kend = cs_v1;
                n_rhs = r_rhs_q;
                n_acc = '0;
                n_diag = '0;
                n_state = (rs_v1 > rs_v0) ? slt_pkg::S_ENT : slt_pkg::S_NUM;
            end
            slt_pkg::S_ENT: begin
                if (r_j + 1'b1 < r_e) begin
                    ent_ra = r_j[EA-1:0];
                    n_state = slt_pkg::S_ENTW;
                end else begin
                    ent_ra = EA'(r_e - 1'b1);
                    n_state = slt_pkg::S_DIAGW;
                end
            end
            slt_pkg::S_ENTW: begin
                n_val = r_ent_q[VB-1:0];
                sol_ra = r_ent_q[RA+VB-1:VB];
                n_state = slt_pkg::S_XW;
            end
            slt_pkg::S_XW: begin
                n_prod = AW'(r_val) * AW'($signed(r_sol_q));
                n_state = slt_pkg::S_ACC;
            end
            slt_pkg::S_ACC: begin
                // arithmetic shift rounds the product toward minus infinity
                sum_wide = (AW+1)'(r_acc) + (AW+1)'(r_prod >>> 16);
                n_acc = slt_pkg::clamp_acc(sum_wide);
                n_j = r_j + 1'b1;
                n_state = slt_pkg::S_ENT;
            end
            slt_pkg::S_DIAGW: begin
                n_diag = r_ent_q[VB-1:0];
                n_state = slt_pkg::S_NUM;
            end
            slt_pkg::S_NUM: begin
                sum_wide = (AW+1)'(r_rhs) - (AW+1)'(r_acc);
                num = slt_pkg::clamp_acc(sum_wide);
                if (r_diag == '0) begin
                    n_zd = 1'b1;
                    sol_we = 1'b1; sol_wa = r_row; sol_wd = '0;
                    n_state = slt_pkg::S_UPD;
                end else begin
                    n_neg = (num < 0) != (r_diag < 0);
                    div_start = 1'b1;
                    div_num = (num < 0) ? slt_pkg::NUM_MAG_W'(-num)
                                        : slt_pkg::NUM_MAG_W'(num);
                    div_den = (r_diag < 0) ? VB'(-r_diag) : VB'(r_diag);
                    n_state = slt_pkg::S_DIV;
                end
            end
            slt_pkg::S_DIV: begin
                if (div_res.done) begin
                    lim = r_neg ? slt_pkg::QUOT_W'(64'd1 << (VB - 1))
                                : slt_pkg::QUOT_W'((64'd1 << (VB - 1)) - 64'd1);
                    big = div_res.ovf || (div_res.quot > lim);
                    sol_we = 1'b1; sol_wa = r_row;
                    if (big) begin
                        n_sat = 1'b1;
                        sol_wd = r_neg ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
                    end else begin
                        sol_wd = r_neg ? VB'(-div_res.quot) : VB'(div_res.quot);
                    end
                    n_state = slt_pkg::S_UPD;
                end
            end
            slt_pkg::S_UPD: begin
                n_solved = r_solved + 1'b1;
                n_state = slt_pkg::S_DEP;
            end
            slt_pkg::S_DEP: begin
                if (r_k < r_kend) begin
                    dep_ra = r_k[EA-1:0];
                    n_k = r_k + 1'b1;
                    n_state = slt_pkg::S_DEPW;
                end else begin
                    n_state = slt_pkg::S_POP;
                end
            end
            slt_pkg::S_DEPW: begin
                n_dep = r_dep_q;
                pend_ra = r_dep_q;
                n_state = (ZW'(r_dep_q) < n_rows) ? slt_pkg::S_PENDW : slt_pkg::S_DEP;
            end
            slt_pkg::S_PENDW: begin
                if (r_pend_q != '0) begin
                    pend_we = 1'b1; pend_wa = r_dep; pend_wd = r_pend_q - 1'b1;
                    if (r_pend_q == RA'(1) && r_tail < ZW'(slt_pkg::MAX_ROWS)) begin
                        fifo_we = 1'b1; fifo_wd = r_dep;
                        n_tail = r_tail + 1'b1;
                    end
                end
                n_state = slt_pkg::S_DEP;
            end
            slt_pkg::S_DONE: begin
                n_out_v = 1'b1;
                n_out.kind = slt_pkg::KIND_REPORT;
                n_out.data = '0;
                n_out.solved_count = r_solved;
                if (r_zd) begin
                    n_out.status = slt_pkg::ST_ZERO_DIAG;
                end else if (r_sat) begin
                    n_out.status = slt_pkg::ST_SATURATED;
                end else if (r_solved < n_rows) begin
                    n_out.status = slt_pkg::ST_UNSOLVED;
                end else begin
                    n_out.status = slt_pkg::ST_OK;
                end
                n_last = r_solved;
                n_row_open = 1'b0;
                n_col_open = 1'b0;
                n_state = slt_pkg::S_IDLE;
            end
            slt_pkg::S_READW: begin
                n_out_v = 1'b1;
                n_out.kind = slt_pkg::KIND_READ;
                n_out.data = r_sol_q;
                n_out.status = slt_pkg::ST_OK;
                n_out.solved_count = r_last;
                n_state = slt_pkg::S_IDLE;
            end
            default: begin
                n_state = slt_pkg::S_IDLE;
            end
        endcase
    end
endmodule

// ----- test/tb_sparse_lower_solve_dependency_driven.sv -----
`timescale 1ns / 1ps
module tb_sparse_lower_solve_dependency_driven;

    localparam int AWAIT_DEPTH = 4096;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    slt_pkg::t_cmd              i_cmd = '0;
    logic                       o_res_valid;
    slt_pkg::t_res              o_res;
    logic                       i_cfg_we = 1'b0;
    logic [slt_pkg::SIZE_W-1:0] i_cfg_data = '0;

    sparse_lower_solve_dependency_driven DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // solver state as seen from outside
    longint    ent_val [slt_pkg::MAX_ENTRIES];
    int        ent_col [slt_pkg::MAX_ENTRIES];
    int        dep_row [slt_pkg::MAX_ENTRIES];
    int        row_start [slt_pkg::MAX_ROWS+1];
    int        col_start [slt_pkg::MAX_ROWS+1];
    longint    rhs_val [slt_pkg::MAX_ROWS];
    bit        rhs_set [slt_pkg::MAX_ROWS];
    longint    x_val [slt_pkg::MAX_ROWS];
    int        pend [slt_pkg::MAX_ROWS];
    int        size_reg;
    int        row_fill, col_fill, last_solved;
    bit        row_open, col_open;

    slt_pkg::t_res awaited_res [AWAIT_DEPTH];
    int        aw_wr = 0;
    int        aw_rd = 0;
    int        errors = 0;
    int        checked = 0;
    int        items_sent = 0;
    int        solves_sent = 0;
    int        idle_pct = 0;
    int        status_seen [4];

    function automatic void await_result(slt_pkg::t_res r);
        awaited_res[aw_wr % AWAIT_DEPTH] = r;
        aw_wr++;
    endfunction

    function automatic longint clamp62(longint a);
        longint lim;
        lim = longint'(1) <<< 62;
        if (a > lim) return lim;
        if (a < -lim) return -lim;
        return a;
    endfunction

    function automatic longint q_div(longint num, longint den, inout bit sat);
        bit         neg;
        logic [63:0] n, d, hi, q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        hi = n / d;
        if (hi >= 64'h1_0000_0000) q = '1;
        else q = (hi << 16) + (((n % d) << 16) / d);
        if (neg) begin
            if (q > 64'h8000_0000) begin
                sat = 1'b1;
                return -64'sh8000_0000;
            end
            return -longint'(q);
        end
        if (q > 64'h7fff_ffff) begin
            sat = 1'b1;
            return 64'sh7fff_ffff;
        end
        return longint'(q);
    endfunction

    function automatic slt_pkg::t_res solve_forward();
        slt_pkg::t_res r;
        int     n, solved, rr, s, e, col;
        int     ready [slt_pkg::MAX_ROWS];
        int     rd_p, wr_p;
        bit     zdiag, sat;
        longint acc, diag, num, xv;
        n = (size_reg > slt_pkg::MAX_ROWS) ? slt_pkg::MAX_ROWS : size_reg;
        solved = 0;
        zdiag = 0;
        sat = 0;
        rd_p = 0;
        wr_p = 0;
        for (int i = 1; i <= slt_pkg::MAX_ROWS; i++) begin
            if (row_start[i] < row_start[i-1]) row_start[i] = row_start[i-1];
            if (col_start[i] < col_start[i-1]) col_start[i] = col_start[i-1];
        end
        for (int i = 0; i < n; i++) begin
            int len;
            len = row_start[i+1] - row_start[i];
            x_val[i] = 0;
            pend[i] = (len == 0) ? 0 :
                      ((len - 1 > slt_pkg::COUNT_MAX) ? slt_pkg::COUNT_MAX : len - 1);
        end
        for (int i = 0; i < n; i++) begin
            if (pend[i] == 0 && wr_p < slt_pkg::MAX_ROWS) begin
                ready[wr_p] = i;
                wr_p++;
            end
        end
        while (rd_p < wr_p) begin
            rr = ready[rd_p];
            rd_p++;
            s = row_start[rr];
            e = row_start[rr+1];
            acc = 0;
            diag = 0;
            if (e > s) begin
                for (int j = s; j + 1 < e; j++) begin
                    col = ent_col[j];
                    xv = x_val[col];
                    acc = clamp62(acc + ((ent_val[j] * xv) >>> 16));
                end
                diag = ent_val[e-1];
            end
            num = clamp62(rhs_val[rr] - acc);
            if (diag == 0) begin
                zdiag = 1;
                x_val[rr] = 0;
            end else begin
                x_val[rr] = q_div(num, diag, sat);
            end
            solved++;
            for (int k = col_start[rr] + 1; k < col_start[rr+1]; k++) begin
                int d;
                d = dep_row[k];
                if (d < n && pend[d] > 0) begin
                    pend[d]--;
                    if (pend[d] == 0 && wr_p < slt_pkg::MAX_ROWS) begin
                        ready[wr_p] = d;
                        wr_p++;
                    end
                end
            end
        end
        r = '0;
        r.kind = slt_pkg::KIND_REPORT;
        if (zdiag) r.status = slt_pkg::ST_ZERO_DIAG;
        else if (sat) r.status = slt_pkg::ST_SATURATED;
        else if (solved < n) r.status = slt_pkg::ST_UNSOLVED;
        else r.status = slt_pkg::ST_OK;
        r.solved_count = solved[slt_pkg::SIZE_W-1:0];
        last_solved = solved;
        row_open = 0;
        col_open = 0;
        return r;
    endfunction

    // update the solver state for one accepted transaction
    function automatic void solver_accept(slt_pkg::t_cmd c);
        slt_pkg::t_res r;
        int   ri, ci;
        ri = c.row_index;
        ci = c.col_index;
        case (c.command)
            slt_pkg::CMD_ROW_ENTRY: begin
                if (!row_open) begin
                    foreach (row_start[i]) row_start[i] = 0;
                    row_fill = 0;
                    row_open = 1;
                end
                if (row_fill < slt_pkg::MAX_ENTRIES) begin
                    ent_val[row_fill] = longint'(c.value);
                    ent_col[row_fill] = ci;
                    row_fill++;
                    row_start[ri+1] = row_fill;
                end
            end
            slt_pkg::CMD_COL_ENTRY: begin
                if (!col_open) begin
                    foreach (col_start[i]) col_start[i] = 0;
                    col_fill = 0;
                    col_open = 1;
                end
                if (col_fill < slt_pkg::MAX_ENTRIES) begin
                    dep_row[col_fill] = ri;
                    col_fill++;
                    col_start[ci+1] = col_fill;
                end
            end
            slt_pkg::CMD_RHS: begin
                rhs_val[ri] = longint'(c.value);
                rhs_set[ri] = 1;
            end
            slt_pkg::CMD_SOLVE: await_result(solve_forward());
            slt_pkg::CMD_READ: begin
                r = '0;
                r.kind = slt_pkg::KIND_READ;
                r.data = x_val[ri][31:0];
                r.status = slt_pkg::ST_OK;
                r.solved_count = last_solved[slt_pkg::SIZE_W-1:0];
                await_result(r);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint exp_v, longint got_v);
        errors++;
        $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    endtask

    always @(posedge i_clk) begin
        slt_pkg::t_res e;
        if (i_rst_n && o_res_valid) begin
            if (aw_wr == aw_rd) begin
                report_mismatch("unexpected result", 0, longint'(o_res));
            end else begin
                e = awaited_res[aw_rd % AWAIT_DEPTH];
                aw_rd++;
                checked++;
                if (o_res.kind !== e.kind) report_mismatch("kind", e.kind, o_res.kind);
                if (o_res.data !== e.data) report_mismatch("data", e.data, o_res.data);
                if (o_res.status !== e.status)
                    report_mismatch("status", e.status, o_res.status);
                if (o_res.solved_count !== e.solved_count)
                    report_mismatch("solved_count", e.solved_count, o_res.solved_count);
                if (e.kind == slt_pkg::KIND_REPORT) status_seen[e.status]++;
            end
        end
    end

    task automatic send_cmd(logic [2:0] op, int row, int col, logic [31:0] val);
        slt_pkg::t_cmd c;
        c.command = op;
        c.row_index = row[slt_pkg::ROW_AW-1:0];
        c.col_index = col[slt_pkg::ROW_AW-1:0];
        c.value = val;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        solver_accept(c);
        items_sent++;
        if (op == slt_pkg::CMD_SOLVE) solves_sent++;
    endtask

    // hold off until every awaited result is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (aw_wr != aw_rd) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_size(int v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[slt_pkg::SIZE_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = v;
    endtask

    task automatic solve_now();
        int n;
        n = (size_reg > slt_pkg::MAX_ROWS) ? slt_pkg::MAX_ROWS : size_reg;
        for (int i = 0; i < n; i++)
            if (!rhs_set[i]) send_cmd(slt_pkg::CMD_RHS, i, 0, $urandom);
        send_cmd(slt_pkg::CMD_SOLVE, $urandom_range(1023), $urandom_range(1023), $urandom);
    endtask

    function automatic logic [31:0] pick_val(bit wide);
        if (wide) return $urandom;
        return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
    endfunction

    function automatic logic [31:0] pick_diag(bit wide);
        logic [31:0] v;
        if (wide) return $urandom;
        v = ($urandom_range(1, 3) << 16) | $urandom_range(0, 65535);
        return $urandom_range(1) ? -v : v;
    endfunction

    // lower-triangular load; flaw: 0 none, 1 dropped column entries, 2 zero diagonal,
    // 3 full-range values, 4 stray dependents and unknown commands
    task automatic load_matrix(int n, int flaw);
        bit pat [0:31][0:31];
        int zrow;
        zrow = $urandom_range(n - 1);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < i; j++) pat[i][j] = ($urandom_range(2) == 0);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < i; j++)
                if (pat[i][j]) send_cmd(slt_pkg::CMD_ROW_ENTRY, i, j, pick_val(flaw == 3));
            send_cmd(slt_pkg::CMD_ROW_ENTRY, i, i,
                     (flaw == 2 && i == zrow) ? 32'd0 : pick_diag(flaw == 3));
        end
        for (int j = 0; j < n; j++) begin
            send_cmd(slt_pkg::CMD_COL_ENTRY, j, j, $urandom);
            for (int i = j + 1; i < n; i++)
                if (pat[i][j] && !(flaw == 1 && $urandom_range(2) == 0))
                    send_cmd(slt_pkg::CMD_COL_ENTRY, i, j, $urandom);
            if (flaw == 4) begin
                send_cmd(slt_pkg::CMD_COL_ENTRY, $urandom_range(n, 1023), j, $urandom);
                send_cmd(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
            end
        end
        for (int i = 0; i < n; i++) send_cmd(slt_pkg::CMD_RHS, i, 0, pick_val(flaw == 3));
    endtask

    task automatic read_some(int n);
        repeat ($urandom_range(1, 4))
            send_cmd(slt_pkg::CMD_READ, $urandom_range(n), 0, $urandom);
        send_cmd(slt_pkg::CMD_READ, $urandom_range(1023), $urandom_range(1023), $urandom);
    endtask

    task automatic test_directed();
        set_size(1);
        solve_now();                                // row with no entries
        send_cmd(slt_pkg::CMD_READ, 0, 0, 0);
        send_cmd(slt_pkg::CMD_READ, 1023, 1023, 32'hffff_ffff);
        send_cmd(3'd5, 1023, 1023, 32'hffff_ffff);
        send_cmd(3'd6, 0, 0, 0);
        send_cmd(3'd7, 512, 512, 32'h8000_0000);
        set_size(0);
        solve_now();
        // saturation with extreme values
        set_size(2);
        send_cmd(slt_pkg::CMD_ROW_ENTRY, 0, 0, 32'h0000_0001);
        send_cmd(slt_pkg::CMD_ROW_ENTRY, 1, 0, 32'h8000_0000);
        send_cmd(slt_pkg::CMD_ROW_ENTRY, 1, 1, 32'h7fff_ffff);
        send_cmd(slt_pkg::CMD_COL_ENTRY, 0, 0, 0);
        send_cmd(slt_pkg::CMD_COL_ENTRY, 1, 0, 0);
        send_cmd(slt_pkg::CMD_COL_ENTRY, 1, 1, 0);
        send_cmd(slt_pkg::CMD_RHS, 0, 0, 32'h7fff_ffff);
        send_cmd(slt_pkg::CMD_RHS, 1, 0, 32'h8000_0000);
        send_cmd(slt_pkg::CMD_RHS, 1023, 0, 32'h8000_0000);
        solve_now();
        send_cmd(slt_pkg::CMD_READ, 0, 0, 0);
        send_cmd(slt_pkg::CMD_READ, 1, 0, 0);
        drain();
    endtask

    task automatic test_unordered_loads();
        set_size(8);
        repeat (12)
            send_cmd(slt_pkg::CMD_ROW_ENTRY, $urandom_range(7), $urandom_range(7), pick_val(0));
        repeat (10)
            send_cmd(slt_pkg::CMD_COL_ENTRY, $urandom_range(9), $urandom_range(7), $urandom);
        solve_now();
        read_some(8);
        drain();
    endtask

    task automatic test_random(int pct, int budget);
        int stop_at, n, flaw;
        idle_pct = pct;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
            flaw = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
            set_size($urandom_range(5) == 0 ? $urandom_range(0, n + 2) : n);
            load_matrix(n, flaw);
            if ($urandom_range(4) == 0)
                repeat (4) send_cmd(3'($urandom_range(7)), $urandom, $urandom, $urandom);
            solve_now();
            read_some(n);
        end
        drain();
    endtask

    initial begin
        foreach (rhs_set[i]) rhs_set[i] = 0;
        foreach (row_start[i]) row_start[i] = 0;
        foreach (col_start[i]) col_start[i] = 0;
        foreach (x_val[i]) x_val[i] = 0;
        foreach (rhs_val[i]) rhs_val[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        size_reg = 1;
        row_fill = 0;
        col_fill = 0;
        last_solved = 0;
        row_open = 0;
        col_open = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_unordered_loads();
        test_random(24, 270);
        test_random(71, 270);
        test_random(0, 270);
        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d transactions, %0d solves, %0d results checked",
                 items_sent, solves_sent, checked);
        $display("solve reports ok/zero-diag/saturated/unsolved: %0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && aw_wr == aw_rd) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
